### rtl/forth_data_stack_alu_core_defines.svh
// shared assertion macros
`ifndef FORTH_DATA_STACK_ALU_CORE_DEFINES_SVH
`define FORTH_DATA_STACK_ALU_CORE_DEFINES_SVH

`define FDSA_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fdsa check failed");

`define FDSA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fdsa check failed");

`endif

### rtl/fdsa_pkg.sv
package fdsa_pkg;

	typedef enum logic [4:0] {
		OP_LIT   = 5'd0,
		OP_DUP   = 5'd1,
		OP_SWAP  = 5'd2,
		OP_ROT   = 5'd3,
		OP_DROP  = 5'd4,
		OP_INC   = 5'd5,
		OP_DEC   = 5'd6,
		OP_SHL   = 5'd7,
		OP_SHR   = 5'd8,
		OP_OR    = 5'd9,
		OP_AND   = 5'd10,
		OP_XOR   = 5'd11,
		OP_NOT   = 5'd12,
		OP_TRUE  = 5'd13,
		OP_FALSE = 5'd14,
		OP_ADD   = 5'd15,
		OP_EMIT  = 5'd16,
		OP_DEPTH = 5'd17
	} op_t;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_UNDER = 2'd1,
		ERR_OVER  = 2'd2
	} err_t;

	localparam int WORD_W  = 32;
	localparam int CMD_W   = 5;
	localparam int DEPTH_W = 11;

	// exec -> core control
	typedef struct packed {
		logic spill;    // write third entry to memory
		logic refill;   // fetch new third entry from memory
		logic emit_ok;
		err_t err;
	} ctl_t;

endpackage

### rtl/fdsa_ram.sv
module fdsa_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [fdsa_pkg::WORD_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [fdsa_pkg::WORD_W-1:0] rdata
);

	logic [fdsa_pkg::WORD_W-1:0] mem [DEPTH];
	logic [fdsa_pkg::WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/fdsa_exec.sv
module fdsa_exec #(
	parameter int STACK_DEPTH = 1024,
	parameter int CW          = 11
) (
	input  logic [fdsa_pkg::CMD_W-1:0]  cmd,
	input  logic [fdsa_pkg::WORD_W-1:0] lit,
	input  logic [fdsa_pkg::WORD_W-1:0] t0,
	input  logic [fdsa_pkg::WORD_W-1:0] t1,
	input  logic [fdsa_pkg::WORD_W-1:0] t2,
	input  logic [CW-1:0]               cnt,
	output logic [fdsa_pkg::WORD_W-1:0] n0,
	output logic [fdsa_pkg::WORD_W-1:0] n1,
	output logic [fdsa_pkg::WORD_W-1:0] n2,
	output logic [CW-1:0]               ncnt,
	output logic [fdsa_pkg::WORD_W-1:0] emit_val,
	output fdsa_pkg::ctl_t              ctl
);

	localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);
	localparam logic [CW-1:0] THREE = CW'(3);
	localparam logic [CW-1:0] FOUR  = CW'(4);

	logic [1:0]                  need;
	logic                        under;
	logic                        is_push;
	logic                        do_push;
	logic                        do_pop;
	logic                        is_bin;
	logic [fdsa_pkg::WORD_W-1:0] pv;
	logic [fdsa_pkg::WORD_W-1:0] res;
	logic [CW+fdsa_pkg::WORD_W-1:0] cnt_ext;

	assign cnt_ext = {{fdsa_pkg::WORD_W{1'b0}}, cnt};

	always_comb begin
		case (cmd) inside
			fdsa_pkg::OP_DUP, fdsa_pkg::OP_DROP, fdsa_pkg::OP_INC, fdsa_pkg::OP_DEC,
			fdsa_pkg::OP_NOT, fdsa_pkg::OP_EMIT: need = 2'd1;
			fdsa_pkg::OP_SWAP, fdsa_pkg::OP_SHL, fdsa_pkg::OP_SHR, fdsa_pkg::OP_OR,
			fdsa_pkg::OP_AND, fdsa_pkg::OP_XOR, fdsa_pkg::OP_ADD: need = 2'd2;
			fdsa_pkg::OP_ROT: need = 2'd3;
			default: need = 2'd0;
		endcase
		is_push = cmd inside {fdsa_pkg::OP_LIT, fdsa_pkg::OP_DUP, fdsa_pkg::OP_TRUE,
			fdsa_pkg::OP_FALSE, fdsa_pkg::OP_DEPTH};
		under = cnt < {{(CW-2){1'b0}}, need};
	end

	always_comb begin
		n0       = t0;
		n1       = t1;
		n2       = t2;
		ncnt     = cnt;
		emit_val = '0;
		pv       = '0;
		res      = '0;
		do_push  = 1'b0;
		do_pop   = 1'b0;
		is_bin   = 1'b0;
		ctl      = '{spill: 1'b0, refill: 1'b0, emit_ok: 1'b0, err: fdsa_pkg::ERR_OK};
		if (under) begin
			ctl.err = fdsa_pkg::ERR_UNDER;
		end else if (is_push && cnt >= FULL) begin
			ctl.err = fdsa_pkg::ERR_OVER;
		end else begin
			case (cmd)
				fdsa_pkg::OP_LIT: begin
					pv = lit;
					do_push = 1'b1;
				end
				fdsa_pkg::OP_DUP: begin
					pv = t0;
					do_push = 1'b1;
				end
				fdsa_pkg::OP_TRUE: begin
					pv = '1;
					do_push = 1'b1;
				end
				fdsa_pkg::OP_FALSE: begin
					pv = '0;
					do_push = 1'b1;
				end
				fdsa_pkg::OP_DEPTH: begin
					pv = cnt_ext[fdsa_pkg::WORD_W-1:0];
					do_push = 1'b1;
				end
				fdsa_pkg::OP_SWAP: begin
					n0 = t1;
					n1 = t0;
				end
				fdsa_pkg::OP_ROT: begin
					n0 = t2;
					n1 = t0;
					n2 = t1;
				end
				fdsa_pkg::OP_DROP: begin
					do_pop = 1'b1;
				end
				fdsa_pkg::OP_EMIT: begin
					do_pop = 1'b1;
					emit_val = t0;
					ctl.emit_ok = 1'b1;
				end
				fdsa_pkg::OP_INC: n0 = t0 + 32'd1;
				fdsa_pkg::OP_DEC: n0 = t0 - 32'd1;
				fdsa_pkg::OP_NOT: n0 = ~t0;
				fdsa_pkg::OP_SHL: begin
					is_bin = 1'b1;
					res = (t0[31:5] != '0) ? '0 : (t1 << t0[4:0]);
				end
				fdsa_pkg::OP_SHR: begin
					is_bin = 1'b1;
					res = (t0[31:5] != '0) ? '0 : (t1 >> t0[4:0]);
				end
				fdsa_pkg::OP_OR: begin
					is_bin = 1'b1;
					res = t1 | t0;
				end
				fdsa_pkg::OP_AND: begin
					is_bin = 1'b1;
					res = t1 & t0;
				end
				fdsa_pkg::OP_XOR: begin
					is_bin = 1'b1;
					res = t1 ^ t0;
				end
				fdsa_pkg::OP_ADD: begin
					is_bin = 1'b1;
					res = t1 + t0;
				end
				default: ;
			endcase
			if (do_push) begin
				n0 = pv;
				n1 = t0;
				n2 = t1;
				ncnt = cnt + CW'(1);
				ctl.spill = cnt >= THREE;
			end
			if (do_pop || is_bin) begin
				n0 = is_bin ? res : t1;
				n1 = t2;
				ncnt = cnt - CW'(1);
				ctl.refill = cnt >= FOUR;
			end
		end
	end

endmodule

### rtl/forth_data_stack_alu_core.sv
// channel | dir | tdata                                | tuser
// s       | in  | [31:0] literal_value                 | [4:0] cmd
// m       | out | [31:0] top_value, [63:32] emitted_value,
//         |     | [74:64] depth                        | [0] emitted_valid, [2:1] error_code
//
// Top three entries live in flops, deeper entries in a single-port-per-side RAM.
// One beat per cycle while the output keeps up, except that a pop with four or more
// entries holds off input in ST_FILL while the RAM read of the new third entry lands.
// Output is registered; input is held off while a result waits and m_tready is low.
// Reset clears the entry count and handshake state only; RAM needs no clearing.
module forth_data_stack_alu_core #(
	parameter int STACK_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] literal_value
	input  logic [7:0]  s_tuser,  // [4:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // [31:0] top_value, [63:32] emitted_value, [74:64] depth
	output logic [7:0]  m_tuser   // [0] emitted_valid, [2:1] error_code
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int W  = fdsa_pkg::WORD_W;

	typedef enum logic [1:0] {
		ST_RUN  = 2'b01,
		ST_FILL = 2'b10
	} state_t;

	state_t         st_q;
	logic [W-1:0]   t0_q, t1_q, t2_q;
	logic [CW-1:0]  cnt_q;
	logic [W-1:0]   n0, n1, n2;
	logic [CW-1:0]  ncnt;
	logic [W-1:0]   emit_val;
	fdsa_pkg::ctl_t ctl;
	logic           acc;
	logic [CW-1:0]  spill_pos, fill_pos;
	logic [W-1:0]   rdata;
	logic [CW+fdsa_pkg::DEPTH_W-1:0] ncnt_ext;

	logic           m_tvalid_q;
	logic [W-1:0]   top_q, emit_q;
	logic           emit_ok_q;
	logic [fdsa_pkg::DEPTH_W-1:0] depth_q;
	fdsa_pkg::err_t err_q;

	assign s_tready = (st_q == ST_RUN) && (!m_tvalid_q || m_tready);
	assign acc      = s_tvalid && s_tready;

	fdsa_exec #(
		.STACK_DEPTH(STACK_DEPTH),
		.CW         (CW)
	) u_exec (
		.cmd     (s_tuser[fdsa_pkg::CMD_W-1:0]),
		.lit     (s_tdata[W-1:0]),
		.t0      (t0_q),
		.t1      (t1_q),
		.t2      (t2_q),
		.cnt     (cnt_q),
		.n0      (n0),
		.n1      (n1),
		.n2      (n2),
		.ncnt    (ncnt),
		.emit_val(emit_val),
		.ctl     (ctl)
	);

	assign spill_pos = cnt_q - CW'(3);
	assign fill_pos  = cnt_q - CW'(4);

	fdsa_ram #(
		.DEPTH(STACK_DEPTH),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (acc && ctl.spill),
		.waddr(spill_pos[AW-1:0]),
		.wdata(t2_q),
		.re   (acc && ctl.refill),
		.raddr(fill_pos[AW-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_RUN;
			cnt_q <= '0;
		end else begin
			case (st_q)
				ST_RUN: begin
					if (acc) begin
						cnt_q <= ncnt;
						if (ctl.refill) begin
							st_q <= ST_FILL;
						end
					end
				end
				ST_FILL: st_q <= ST_RUN;
				default: st_q <= ST_RUN;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			t0_q <= n0;
			t1_q <= n1;
			t2_q <= n2;
		end else if (st_q == ST_FILL) begin
			t2_q <= rdata;
		end
	end

	assign ncnt_ext = {{fdsa_pkg::DEPTH_W{1'b0}}, ncnt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (acc) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			top_q     <= (ncnt != '0) ? n0 : '0;
			emit_q    <= emit_val;
			emit_ok_q <= ctl.emit_ok;
			depth_q   <= ncnt_ext[fdsa_pkg::DEPTH_W-1:0];
			err_q     <= ctl.err;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, depth_q, emit_q, top_q};
	assign m_tuser  = {5'd0, err_q, emit_ok_q};

endmodule

### rtl/fdsa_chk.sv
`include "forth_data_stack_alu_core_defines.svh"

module fdsa_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [79:0] m_tdata,
	input logic [7:0]  m_tuser
);

	`FDSA_ASSERT_IMPLY(a_err_code, m_tvalid, m_tuser[2:1] != 2'd3)
	`FDSA_ASSERT_IMPLY(a_emit_ok, m_tvalid && m_tuser[0], m_tuser[2:1] == fdsa_pkg::ERR_OK)
	`FDSA_ASSERT_IMPLY(a_emit_zero, m_tvalid && !m_tuser[0], m_tdata[63:32] == 32'd0)
	`FDSA_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind forth_data_stack_alu_core fdsa_chk u_fdsa_chk (.*);

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int STACK_DEPTH = 1024;
	localparam int CYCLE_LIMIT = 500000;
	localparam int TAIL_CYCLES = 16;
	localparam int MAX_PRINTS  = 40;
	localparam logic [4:0] CMD_UNUSED_LO = 5'd18;
	localparam logic [4:0] CMD_UNUSED_HI = 5'd31;

	typedef struct {
		logic [31:0]    top_value;
		logic [31:0]    emitted_value;
		logic           emitted_valid;
		logic [10:0]    depth;
		fdsa_pkg::err_t error_code;
	} stack_result_t;

	typedef struct {
		bit            pin;
		logic [4:0]    cmd;
		logic [31:0]   lit;
		stack_result_t want;
	} stack_row_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;  // [31:0] literal_value
	logic [7:0]  s_tuser  = '0;  // [4:0] cmd
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;        // [31:0] top_value, [63:32] emitted_value, [74:64] depth
	logic [7:0]  m_tuser;        // [0] emitted_valid, [2:1] error_code

	forth_data_stack_alu_core #(
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// shadow stack
	logic [31:0]   stack_mem [STACK_DEPTH];
	int            stack_cnt = 0;
	stack_result_t expect_q [$];
	stack_row_t    launch_q [$];
	int            fail_cnt  = 0;
	int            cycle_cnt = 0;
	int            est_cnt   = 0;
	int            burst_left = 1;

	fdsa_pkg::op_t grow_ops  [5] = '{fdsa_pkg::OP_LIT, fdsa_pkg::OP_DUP, fdsa_pkg::OP_TRUE,
		fdsa_pkg::OP_FALSE, fdsa_pkg::OP_DEPTH};
	fdsa_pkg::op_t alter_ops [5] = '{fdsa_pkg::OP_INC, fdsa_pkg::OP_DEC, fdsa_pkg::OP_NOT,
		fdsa_pkg::OP_SWAP, fdsa_pkg::OP_ROT};
	fdsa_pkg::op_t pop_ops   [8] = '{fdsa_pkg::OP_EMIT, fdsa_pkg::OP_DROP, fdsa_pkg::OP_ADD,
		fdsa_pkg::OP_OR, fdsa_pkg::OP_AND, fdsa_pkg::OP_XOR, fdsa_pkg::OP_SHL,
		fdsa_pkg::OP_SHR};

	function automatic int op_needs(input logic [4:0] cmd);
		case (cmd)
			fdsa_pkg::OP_DUP, fdsa_pkg::OP_DROP, fdsa_pkg::OP_INC, fdsa_pkg::OP_DEC,
			fdsa_pkg::OP_NOT, fdsa_pkg::OP_EMIT: return 1;
			fdsa_pkg::OP_SWAP, fdsa_pkg::OP_SHL, fdsa_pkg::OP_SHR, fdsa_pkg::OP_OR,
			fdsa_pkg::OP_AND, fdsa_pkg::OP_XOR, fdsa_pkg::OP_ADD: return 2;
			fdsa_pkg::OP_ROT: return 3;
			default: return 0;
		endcase
	endfunction

	function automatic bit op_grows(input logic [4:0] cmd);
		return cmd == fdsa_pkg::OP_LIT || cmd == fdsa_pkg::OP_DUP ||
			cmd == fdsa_pkg::OP_TRUE || cmd == fdsa_pkg::OP_FALSE ||
			cmd == fdsa_pkg::OP_DEPTH;
	endfunction

	function automatic int count_after(input int cnt, input logic [4:0] cmd);
		if (cnt < op_needs(cmd))
			return cnt;
		if (op_grows(cmd))
			return (cnt >= STACK_DEPTH) ? cnt : cnt + 1;
		case (cmd)
			fdsa_pkg::OP_DROP, fdsa_pkg::OP_EMIT, fdsa_pkg::OP_SHL, fdsa_pkg::OP_SHR,
			fdsa_pkg::OP_OR, fdsa_pkg::OP_AND, fdsa_pkg::OP_XOR,
			fdsa_pkg::OP_ADD: return cnt - 1;
			default: return cnt;
		endcase
	endfunction

	function automatic stack_result_t forth_exec(input logic [4:0] cmd, input logic [31:0] lit);
		stack_result_t r;
		logic [31:0]   a;
		logic [31:0]   b;
		logic [31:0]   c;
		r.emitted_value = '0;
		r.emitted_valid = 1'b0;
		r.error_code    = fdsa_pkg::ERR_OK;
		if (stack_cnt < op_needs(cmd)) begin
			r.error_code = fdsa_pkg::ERR_UNDER;
		end else if (op_grows(cmd) && stack_cnt >= STACK_DEPTH) begin
			r.error_code = fdsa_pkg::ERR_OVER;
		end else begin
			case (cmd)
				fdsa_pkg::OP_LIT, fdsa_pkg::OP_DUP, fdsa_pkg::OP_TRUE, fdsa_pkg::OP_FALSE,
				fdsa_pkg::OP_DEPTH: begin
					case (cmd)
						fdsa_pkg::OP_LIT:   a = lit;
						fdsa_pkg::OP_DUP:   a = stack_mem[stack_cnt - 1];
						fdsa_pkg::OP_TRUE:  a = '1;
						fdsa_pkg::OP_FALSE: a = '0;
						default:            a = 32'(stack_cnt);
					endcase
					stack_mem[stack_cnt] = a;
					stack_cnt++;
				end
				fdsa_pkg::OP_SWAP: begin
					a = stack_mem[stack_cnt - 2];
					stack_mem[stack_cnt - 2] = stack_mem[stack_cnt - 1];
					stack_mem[stack_cnt - 1] = a;
				end
				fdsa_pkg::OP_ROT: begin
					a = stack_mem[stack_cnt - 3];
					stack_mem[stack_cnt - 3] = stack_mem[stack_cnt - 2];
					stack_mem[stack_cnt - 2] = stack_mem[stack_cnt - 1];
					stack_mem[stack_cnt - 1] = a;
				end
				fdsa_pkg::OP_DROP: stack_cnt--;
				fdsa_pkg::OP_INC:
					stack_mem[stack_cnt - 1] = stack_mem[stack_cnt - 1] + 32'd1;
				fdsa_pkg::OP_DEC:
					stack_mem[stack_cnt - 1] = stack_mem[stack_cnt - 1] - 32'd1;
				fdsa_pkg::OP_NOT:
					stack_mem[stack_cnt - 1] = ~stack_mem[stack_cnt - 1];
				fdsa_pkg::OP_SHL, fdsa_pkg::OP_SHR, fdsa_pkg::OP_OR, fdsa_pkg::OP_AND,
				fdsa_pkg::OP_XOR, fdsa_pkg::OP_ADD: begin
					a = stack_mem[stack_cnt - 2];
					b = stack_mem[stack_cnt - 1];
					case (cmd)
						fdsa_pkg::OP_SHL: c = (b >= 32) ? 32'd0 : a << b[4:0];
						fdsa_pkg::OP_SHR: c = (b >= 32) ? 32'd0 : a >> b[4:0];
						fdsa_pkg::OP_OR:  c = a | b;
						fdsa_pkg::OP_AND: c = a & b;
						fdsa_pkg::OP_XOR: c = a ^ b;
						default:          c = a + b;
					endcase
					stack_cnt--;
					stack_mem[stack_cnt - 1] = c;
				end
				fdsa_pkg::OP_EMIT: begin
					r.emitted_value = stack_mem[stack_cnt - 1];
					r.emitted_valid = 1'b1;
					stack_cnt--;
				end
				default: ;
			endcase
		end
		r.top_value = (stack_cnt > 0) ? stack_mem[stack_cnt - 1] : 32'd0;
		r.depth     = 11'(stack_cnt);
		return r;
	endfunction

	function automatic stack_row_t mk(input bit pin, input logic [4:0] cmd,
			input logic [31:0] lit, input logic [31:0] top = '0,
			input logic [10:0] dep = '0, input fdsa_pkg::err_t err = fdsa_pkg::ERR_OK);
		stack_row_t row;
		row.pin                = pin;
		row.cmd                = cmd;
		row.lit                = lit;
		row.want.top_value     = top;
		row.want.emitted_value = '0;
		row.want.emitted_valid = 1'b0;
		row.want.depth         = dep;
		row.want.error_code    = err;
		return row;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return 32'($urandom_range(0, 40));
			3:       return 32'($urandom_range(32, 34)) << $urandom_range(0, 26);
			default: return $urandom;
		endcase
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		fail_cnt++;
		if (fail_cnt <= MAX_PRINTS)
			$display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycle_cnt);
	endtask

	task automatic send_beat(input stack_row_t row);
		int gap;
		launch_q.push_back(row);
		est_cnt = count_after(est_cnt, row.cmd);
		s_tvalid <= 1'b1;
		s_tdata  <= row.lit;
		s_tuser  <= {3'b000, row.cmd};
		do @(posedge clk); while (!s_tready);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expect_q.size() != 0 || launch_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_mixed(input int n);
		logic [4:0] cmd;
		repeat (n) begin
			if ($urandom_range(0, 99) < 8) begin
				cmd = 5'($urandom_range(0, 31));
			end else begin
				cmd = 5'($urandom_range(0, 17));
				if (op_needs(cmd) > est_cnt && $urandom_range(0, 7) != 0)
					cmd = fdsa_pkg::OP_LIT;
				else if (op_grows(cmd) && est_cnt > 48 && $urandom_range(0, 1) == 1)
					cmd = fdsa_pkg::OP_EMIT;
			end
			send_beat(mk(0, cmd, rand_word()));
		end
	endtask

	// fill to the top, hit overflow, then pop part way back down
	task automatic send_fill_drain();
		logic [4:0] cmd;
		while (est_cnt < STACK_DEPTH) begin
			if (est_cnt >= 3 && $urandom_range(0, 99) < 2)
				cmd = alter_ops[$urandom_range(0, 4)];
			else if ($urandom_range(0, 1) == 1)
				cmd = fdsa_pkg::OP_LIT;
			else
				cmd = grow_ops[$urandom_range(0, 4)];
			send_beat(mk(0, cmd, rand_word()));
		end
		foreach (grow_ops[i])
			send_beat(mk(0, grow_ops[i], rand_word()));
		send_beat(mk(0, fdsa_pkg::OP_ROT, '0));
		send_beat(mk(0, fdsa_pkg::OP_LIT, '1));
		while (est_cnt > STACK_DEPTH - 32) begin
			if ($urandom_range(0, 9) == 0)
				cmd = alter_ops[$urandom_range(0, 2)];
			else
				cmd = pop_ops[$urandom_range(0, 7)];
			send_beat(mk(0, cmd, rand_word()));
		end
	endtask

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// receiver backpressure: the mode and pattern are redrawn whenever rdy_left runs out
	int         rdy_left = 0;
	int         rdy_mode = 0;
	logic [7:0] rdy_pat  = 8'h01;

	always @(posedge clk) begin
		if (rdy_left == 0) begin
			rdy_left <= $urandom_range(16, 96);
			rdy_mode <= $urandom_range(0, 3);
			rdy_pat  <= 8'($urandom) | 8'h01;
		end else begin
			rdy_left <= rdy_left - 1;
			rdy_pat  <= {rdy_pat[6:0], rdy_pat[7]};
		end
		case (rdy_mode)
			0:       m_tready <= 1'b1;
			1:       m_tready <= rdy_pat[0];
			2:       m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	always @(posedge clk) begin : result_check
		stack_result_t want;
		stack_row_t    row;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				want = forth_exec(s_tuser[4:0], s_tdata[31:0]);
				if (launch_q.size() != 0) begin
					row = launch_q.pop_front();
					if (row.pin)
						want = row.want;
				end
				expect_q.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				if (expect_q.size() == 0) begin
					report("unexpected beat", m_tdata[31:0], '0);
				end else begin
					want = expect_q.pop_front();
					if (m_tdata[31:0] !== want.top_value)
						report("top_value", m_tdata[31:0], want.top_value);
					if (m_tdata[63:32] !== want.emitted_value)
						report("emitted_value", m_tdata[63:32], want.emitted_value);
					if (m_tdata[74:64] !== want.depth)
						report("depth", 32'(m_tdata[74:64]), 32'(want.depth));
					if (m_tuser[0] !== want.emitted_valid)
						report("emitted_valid", 32'(m_tuser[0]), 32'(want.emitted_valid));
					if (m_tuser[2:1] !== want.error_code)
						report("error_code", 32'(m_tuser[2:1]), 32'(want.error_code));
				end
			end
		end
	end

	initial begin : stimulus
		stack_row_t rows [$];
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows.push_back(mk(1, fdsa_pkg::OP_EMIT, 32'h1234_5678, 32'd0, 11'd0,
			fdsa_pkg::ERR_UNDER));
		rows.push_back(mk(1, fdsa_pkg::OP_DROP, 32'd0, 32'd0, 11'd0, fdsa_pkg::ERR_UNDER));
		rows.push_back(mk(1, fdsa_pkg::OP_ROT, 32'd0, 32'd0, 11'd0, fdsa_pkg::ERR_UNDER));
		rows.push_back(mk(1, fdsa_pkg::OP_LIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd1));
		rows.push_back(mk(1, fdsa_pkg::OP_SWAP, 32'd0, 32'hFFFF_FFFF, 11'd1,
			fdsa_pkg::ERR_UNDER));
		rows.push_back(mk(1, fdsa_pkg::OP_INC, 32'd0, 32'd0, 11'd1));
		rows.push_back(mk(1, fdsa_pkg::OP_DEC, 32'd0, 32'hFFFF_FFFF, 11'd1));
		rows.push_back(mk(1, fdsa_pkg::OP_LIT, 32'd0, 32'd0, 11'd2));
		rows.push_back(mk(1, fdsa_pkg::OP_ROT, 32'd0, 32'd0, 11'd2, fdsa_pkg::ERR_UNDER));
		rows.push_back(mk(1, fdsa_pkg::OP_DEPTH, 32'd0, 32'd2, 11'd3));
		rows.push_back(mk(0, fdsa_pkg::OP_ROT, 32'd0));
		rows.push_back(mk(0, fdsa_pkg::OP_SWAP, 32'd0));
		rows.push_back(mk(1, fdsa_pkg::OP_LIT, 32'd32, 32'd32, 11'd4));
		rows.push_back(mk(1, fdsa_pkg::OP_SHL, 32'd0, 32'd0, 11'd3));
		rows.push_back(mk(1, fdsa_pkg::OP_LIT, 32'd33, 32'd33, 11'd4));
		rows.push_back(mk(1, fdsa_pkg::OP_SHR, 32'd0, 32'd0, 11'd3));
		rows.push_back(mk(1, fdsa_pkg::OP_LIT, 32'h8000_0001, 32'h8000_0001, 11'd4));
		rows.push_back(mk(1, fdsa_pkg::OP_LIT, 32'd31, 32'd31, 11'd5));
		rows.push_back(mk(1, fdsa_pkg::OP_SHL, 32'd0, 32'h8000_0000, 11'd4));
		rows.push_back(mk(0, fdsa_pkg::OP_LIT, 32'd31));
		rows.push_back(mk(0, fdsa_pkg::OP_SHR, 32'd0));
		rows.push_back(mk(0, fdsa_pkg::OP_TRUE, 32'd0));
		rows.push_back(mk(0, fdsa_pkg::OP_FALSE, 32'd0));
		rows.push_back(mk(0, fdsa_pkg::OP_OR, 32'd0));
		rows.push_back(mk(0, fdsa_pkg::OP_AND, 32'd0));
		rows.push_back(mk(0, fdsa_pkg::OP_XOR, 32'd0));
		rows.push_back(mk(0, fdsa_pkg::OP_NOT, 32'd0));
		rows.push_back(mk(0, fdsa_pkg::OP_ADD, 32'd0));
		rows.push_back(mk(0, fdsa_pkg::OP_DUP, 32'd0));
		rows.push_back(mk(0, CMD_UNUSED_LO, 32'hA5A5_5A5A));
		rows.push_back(mk(0, CMD_UNUSED_HI, 32'hFFFF_FFFF));
		rows.push_back(mk(0, fdsa_pkg::OP_EMIT, 32'd0));
		foreach (rows[i])
			send_beat(rows[i]);

		// hold off until the pipe is empty
		wait_quiet();
		send_mixed(80);
		send_fill_drain();

		wait_quiet();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_cnt == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### forth_data_stack_alu_core.f
+incdir+rtl
rtl/fdsa_pkg.sv
rtl/fdsa_ram.sv
rtl/fdsa_exec.sv
rtl/forth_data_stack_alu_core.sv
rtl/fdsa_chk.sv
dv/tb_top.sv
